// ----- hdl/sfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and the byte-wide CRC-16/ARC update for the
// sync-framed receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int          HEADER_BYTES   = 10;
    localparam logic [7:0]  SYNC_BYTE      = 8'h3E;
    localparam logic [15:0] CRC_POLY_REFL  = 16'hA001;
    localparam logic [16:0] MAX_BYTES_RST  = 17'd65545;

    typedef enum logic [2:0] {
        ST_BUSY  = 3'd0,
        ST_GOOD  = 3'd1,
        ST_BAD   = 3'd2,
        ST_OWN   = 3'd3,
        ST_LARGE = 3'd4
    } frame_status_t;

    // one result word from the parser
    typedef struct packed {
        logic          valid;
        logic [7:0]    payload_byte;
        logic          byte_valid;
        logic [7:0]    frame_topic;
        logic          frame_end;
        frame_status_t frame_status;
    } sfr_result_t;

    // reflected CRC-16, one byte, unrolled over eight bit steps
    function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc,
                                                   input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/sfr_parse.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_parse
// Frame parser: sync hunt, header capture, payload pass-through with CRC.
// Result is combinational from state and byte; state advances on step.
// ----------------------------------------------------------------------------
module sfr_parse
    import sfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [7:0]  own_id,
    input  wire logic [16:0] max_bytes,
    output sfr_result_t      res
);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    localparam logic [2:0] HP_TOPIC  = 3'd0;
    localparam logic [2:0] HP_SENDER = 3'd1;
    localparam logic [2:0] HP_LEN_HI = 3'd3;
    localparam logic [2:0] HP_LEN_LO = 3'd4;
    localparam logic [2:0] HP_CRC_HI = 3'd5;
    localparam logic [2:0] HP_CRC_LO = 3'd6;
    localparam logic [1:0] SYNC_LAST = 2'd2;

    phase_t      phase_reg,  phase_next;
    logic [1:0]  sync_reg,   sync_next;
    logic [2:0]  hpos_reg,   hpos_next;
    logic [7:0]  topic_reg,  topic_next;
    logic [7:0]  sender_reg, sender_next;
    logic [15:0] left_reg,   left_next;
    logic [15:0] exp_reg,    exp_next;
    logic [15:0] crc_reg,    crc_next;
    logic        too_large;

    assign too_large = ({1'b0, left_reg} + 17'(HEADER_BYTES)) > max_bytes;

    always_comb begin
        phase_next  = phase_reg;
        sync_next   = sync_reg;
        hpos_next   = hpos_reg;
        topic_next  = topic_reg;
        sender_next = sender_reg;
        left_next   = left_reg;
        exp_next    = exp_reg;
        crc_next    = crc_reg;

        res.valid        = 1'b0;
        res.payload_byte = 8'h00;
        res.byte_valid   = 1'b0;
        res.frame_topic  = topic_reg;
        res.frame_end    = 1'b0;
        res.frame_status = ST_BUSY;

        case (phase_reg)
            PH_HEADER: begin
                case (hpos_reg)
                    HP_TOPIC:  topic_next  = rx_byte;
                    HP_SENDER: sender_next = rx_byte;
                    HP_LEN_HI: left_next   = {rx_byte, 8'h00};
                    HP_LEN_LO: left_next   = {left_reg[15:8], rx_byte};
                    HP_CRC_HI: exp_next    = {rx_byte, 8'h00};
                    HP_CRC_LO: exp_next    = {exp_reg[15:8], rx_byte};
                    default:   ; // sequence byte, ignored
                endcase
                if (hpos_reg < HP_CRC_LO) begin
                    hpos_next = hpos_reg + 3'd1;
                end else begin
                    hpos_next       = 3'd0;
                    sync_next       = 2'd0;
                    crc_next        = 16'h0000;
                    phase_next      = PH_HUNT;
                    res.valid       = 1'b1;
                    res.frame_end   = 1'b1;
                    if (sender_reg == own_id) begin
                        res.frame_status = ST_OWN;
                    end else if (too_large) begin
                        res.frame_status = ST_LARGE;
                    end else if (left_reg == 16'h0000) begin
                        res.frame_status = (exp_next == 16'h0000) ? ST_GOOD : ST_BAD;
                    end else begin
                        res.valid     = 1'b0;
                        res.frame_end = 1'b0;
                        phase_next    = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                crc_next         = crc16_arc_byte(crc_reg, rx_byte);
                left_next        = left_reg - 16'd1;
                res.valid        = 1'b1;
                res.payload_byte = rx_byte;
                res.byte_valid   = 1'b1;
                if (left_reg == 16'd1) begin
                    phase_next       = PH_HUNT;
                    res.frame_end    = 1'b1;
                    res.frame_status = (crc_next == exp_reg) ? ST_GOOD : ST_BAD;
                end
            end
            default: begin
                // hunting; the unused phase code lands here too
                phase_next = PH_HUNT;
                if (rx_byte == SYNC_BYTE) begin
                    if (sync_reg == SYNC_LAST) begin
                        sync_next  = 2'd0;
                        hpos_next  = 3'd0;
                        phase_next = PH_HEADER;
                    end else begin
                        sync_next = sync_reg + 2'd1;
                    end
                end else begin
                    sync_next = 2'd0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            sync_reg   <= 2'd0;
            hpos_reg   <= 3'd0;
            topic_reg  <= 8'h00;
            sender_reg <= 8'h00;
            left_reg   <= 16'h0000;
            exp_reg    <= 16'h0000;
            crc_reg    <= 16'h0000;
        end else if (step) begin
            phase_reg  <= phase_next;
            sync_reg   <= sync_next;
            hpos_reg   <= hpos_next;
            topic_reg  <= topic_next;
            sender_reg <= sender_next;
            left_reg   <= left_next;
            exp_reg    <= exp_next;
            crc_reg    <= crc_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/sync_frame_receiver_crc16.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc16
// Byte-stream receiver for '>>>'-synced frames with CRC-16/ARC check.
// ----------------------------------------------------------------------------
// Usage:
//   s_*   : one received link byte per word (s_rx_byte).
//   m_*   : at most one result word per input byte: a payload byte tagged
//           with the frame topic, a frame verdict (crc good/bad, own sender,
//           too large) or both. m_frame_end marks the last word of a frame.
//   cfg_* : register writes, index 0 = own system id, 1 = max frame bytes.
//           cfg_ready is always high; write only while the block is idle.
// Timing:
//   An accepted byte is parsed from the input register by the FSM and CRC
//   update in the following cycle; its result is then registered into the
//   result register that drives m_valid, unless a stalled output holds it.
//   Throughput is one byte per cycle while no result waits on a stalled m_ side.
// Reset (aresetn low, synchronous): parser back to sync hunt, registers to
//   0 / 65545, both word registers empty.
// Back-pressure: while m_ready is low the result register holds; bytes that
//   give no result keep flowing, the next result-bearing byte waits in the
//   input register and s_ready drops until the output drains.
// ----------------------------------------------------------------------------
module sync_frame_receiver_crc16
    import sfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input byte channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_payload_byte,
    output logic             m_byte_valid,
    output logic [7:0]       m_frame_topic,
    output logic             m_frame_end,
    output logic [2:0]       m_frame_status,
    // config write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    localparam logic [1:0] CFG_OWN_ID    = 2'd0;
    localparam logic [1:0] CFG_MAX_BYTES = 2'd1;

    // config registers
    logic [7:0]  own_id_reg;
    logic [16:0] max_bytes_reg;

    // input register
    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_byte_reg;

    // result register
    logic        out_vld_reg, out_vld_next;
    sfr_result_t out_reg;

    sfr_result_t res;
    logic        advance;
    logic        s_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg    <= 8'h00;
            max_bytes_reg <= MAX_BYTES_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_OWN_ID:    own_id_reg    <= cfg_data[7:0];
                CFG_MAX_BYTES: max_bytes_reg <= cfg_data;
                default:       ; // unmapped index, dropped
            endcase
        end
    end

    // byte in the input register moves on unless it makes a result that
    // the stalled output register cannot take
    assign advance = in_vld_reg && (!res.valid || !out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_take  = s_valid && s_ready;

    sfr_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .own_id    (own_id_reg),
        .max_bytes (max_bytes_reg),
        .res       (res)
    );

    always_comb begin
        in_vld_next = s_take || (in_vld_reg && !advance);
        if (advance && res.valid) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_byte_valid   = out_reg.byte_valid;
    assign m_frame_topic  = out_reg.frame_topic;
    assign m_frame_end    = out_reg.frame_end;
    assign m_frame_status = out_reg.frame_status;

`ifndef SYNTHESIS
    // empty input register always takes a byte
    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_ready)
        else $error("s_ready low with empty input register");

    // a frame verdict and frame_end always go together
    a_end_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_end == (m_frame_status != ST_BUSY)))
        else $error("frame_end and status disagree");

    // a word without a payload byte only ever closes a frame
    a_nodata_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> (m_frame_end && m_payload_byte == 8'h00))
        else $error("non-payload word not a frame end");

    // no result may overwrite a stalled one
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready && res.valid) |-> !advance)
        else $error("result register overrun");
`endif

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for sync_frame_receiver_crc16
// Streams '>>>'-synced frames, noise and broken frames into the receiver,
// predicts every result word with a bytewise parser and CRC-16/ARC of its own,
// and checks the m_ side word by word under random idling and back-pressure,
// across several own-id / max-size register settings.
// ----------------------------------------------------------------------------
module testbench;
    import sfr_pkg::*;

    localparam logic [1:0] REG_OWN_ID    = 2'd0;
    localparam logic [1:0] REG_MAX_BYTES = 2'd1;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;     // input reg + parser + output reg, with slack
    localparam int PHASE_BYTES  = 285;   // minimum frame bytes per random phase

    // parser state codes of the predictor
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } parse_phase_t;

    // one expected result word
    typedef struct packed {
        logic [7:0]    data;
        logic          byte_valid;
        logic [7:0]    topic;
        logic          frame_end;
        frame_status_t status;
    } rx_word_t;

    // ------------------------------------------------------------------------
    // Frame tracker: follows the byte stream as the receiver must and keeps
    // the words it owes, oldest first.
    // ------------------------------------------------------------------------
    class rx_frame_tracker;
        parse_phase_t phase;
        logic [1:0]   sync_cnt;
        logic [2:0]   hdr_pos;
        logic [7:0]   topic;
        logic [7:0]   sender;
        logic [15:0]  bytes_left;
        logic [15:0]  crc_hdr;
        logic [15:0]  crc_run;
        logic [7:0]   own_id;
        logic [16:0]  max_bytes;
        rx_word_t     due_words[$];
        int           errors;
        int           words_checked;
        int           verdicts[8];

        function new();
            phase      = PH_HUNT;
            sync_cnt   = 0;
            hdr_pos    = 0;
            topic      = 0;
            sender     = 0;
            bytes_left = 0;
            crc_hdr    = 0;
            crc_run    = 0;
            own_id     = 0;
            max_bytes  = MAX_BYTES_RST;
            errors     = 0;
            words_checked = 0;
            foreach (verdicts[i]) verdicts[i] = 0;
        endfunction

        // reflected CRC-16/ARC, one byte
        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] d);
            logic [15:0] c;
            c = crc ^ {8'h00, d};
            repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            return c;
        endfunction

        function void write_reg(logic [1:0] idx, logic [16:0] value);
            if (idx == REG_OWN_ID)
                own_id = value[7:0];
            else if (idx == REG_MAX_BYTES)
                max_bytes = value;
        endfunction

        function void owe(logic [7:0] d, logic bv, logic fend, frame_status_t st);
            rx_word_t w;
            w.data       = d;
            w.byte_valid = bv;
            w.topic      = topic;
            w.frame_end  = fend;
            w.status     = st;
            due_words.push_back(w);
        endfunction

        function void note_rx_byte(logic [7:0] b);
            case (phase)
                PH_HEADER: begin
                    case (hdr_pos)
                        3'd0: topic = b;
                        3'd1: sender = b;
                        3'd2: ;                          // sequence, unused
                        3'd3: bytes_left = {b, 8'h00};
                        3'd4: bytes_left[7:0] = b;
                        3'd5: crc_hdr = {b, 8'h00};
                        default: crc_hdr[7:0] = b;
                    endcase
                    if (hdr_pos < 3'd6) begin
                        hdr_pos++;
                    end else begin
                        hdr_pos  = 0;
                        sync_cnt = 0;
                        crc_run  = 0;
                        // own sender wins over size
                        if (sender == own_id) begin
                            phase = PH_HUNT;
                            owe(8'h00, 1'b0, 1'b1, ST_OWN);
                        end else if (HEADER_BYTES + int'(bytes_left) > int'(max_bytes)) begin
                            phase = PH_HUNT;
                            owe(8'h00, 1'b0, 1'b1, ST_LARGE);
                        end else if (bytes_left == 0) begin
                            phase = PH_HUNT;
                            owe(8'h00, 1'b0, 1'b1, (crc_hdr == 0) ? ST_GOOD : ST_BAD);
                        end else begin
                            phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    crc_run = crc_step(crc_run, b);
                    bytes_left--;
                    if (bytes_left == 0) begin
                        phase = PH_HUNT;
                        owe(b, 1'b1, 1'b1, (crc_run == crc_hdr) ? ST_GOOD : ST_BAD);
                    end else begin
                        owe(b, 1'b1, 1'b0, ST_BUSY);
                    end
                end
                default: begin
                    // sync hunt; a fourth '>' lands in the header as topic
                    phase = PH_HUNT;
                    if (b == SYNC_BYTE) begin
                        sync_cnt++;
                        if (sync_cnt >= 2'd3) begin
                            sync_cnt = 0;
                            hdr_pos  = 0;
                            phase    = PH_HEADER;
                        end
                    end else begin
                        sync_cnt = 0;
                    end
                end
            endcase
        endfunction

        function void cmp_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_word(logic [7:0] d, logic bv, logic [7:0] tp, logic fend,
                                 logic [2:0] st);
            rx_word_t w;
            if (due_words.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected word, expected none actual data %0h status %0d",
                         $time, d, st);
                return;
            end
            w = due_words.pop_front();
            words_checked++;
            cmp_field("payload_byte", w.data, d);
            cmp_field("byte_valid", w.byte_valid, bv);
            cmp_field("frame_topic", w.topic, tp);
            cmp_field("frame_end", w.frame_end, fend);
            cmp_field("frame_status", int'(w.status), st);
            if (w.frame_end)
                verdicts[w.status]++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_payload_byte;
    logic        m_byte_valid;
    logic [7:0]  m_frame_topic;
    logic        m_frame_end;
    logic [2:0]  m_frame_status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [16:0] cfg_data = 17'd0;

    sync_frame_receiver_crc16 u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_byte_valid   (m_byte_valid),
        .m_frame_topic  (m_frame_topic),
        .m_frame_end    (m_frame_end),
        .m_frame_status (m_frame_status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    rx_frame_tracker tracker = new();

    bit          quiet = 1'b0;      // no idling on either side
    int          cycle_count = 0;
    int          ready_hold = 0;
    int          frame_bytes = 0;
    int          frames_sent = 0;
    logic [7:0]  cur_own = 8'h00;   // settings as the stimulus sees them
    int          cur_max = MAX_BYTES_RST;

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sync_frame_receiver_crc16 test failed");
            $finish;
        end
    end

    // all handshakes sampled at the rising edge, before the DUT updates
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.note_rx_byte(s_rx_byte);
            if (m_valid && m_ready)
                tracker.check_word(m_payload_byte, m_byte_valid, m_frame_topic,
                                   m_frame_end, m_frame_status);
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
        end
    end

    // result side back-pressure: m_ready dropped in random-length bursts
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready = 1'b0;
            ready_hold--;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            m_ready = 1'b0;
            ready_hold = $urandom_range(0, 14);
        end else begin
            m_ready = 1'b1;
        end
    end

    // one byte word; optional idle burst first, valid held until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 9) == 0)
            gap = $urandom_range(1, 15);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_rx_byte = b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sync, 7-byte header, payload; payload only when the frame would pass.
    // cut drops the tail of the payload (a broken frame).
    task automatic send_frame(input logic [7:0] topic, input logic [7:0] sender,
                              input logic [15:0] len, input bit crc_ok, input int cut);
        logic [7:0]  body[$];
        logic [15:0] crc;
        int          npay;
        int          nsend;
        crc  = 16'h0000;
        npay = (sender != cur_own && HEADER_BYTES + int'(len) <= cur_max) ? int'(len) : 0;
        for (int i = 0; i < npay; i++) begin
            body.push_back(8'($urandom));
            crc = rx_frame_tracker::crc_step(crc, body[i]);
        end
        if (!crc_ok)
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        repeat (3) send_byte(SYNC_BYTE);
        send_byte(topic);
        send_byte(sender);
        send_byte(8'($urandom));            // sequence
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
        nsend = (cut < npay) ? npay - cut : npay;
        for (int i = 0; i < nsend; i++)
            send_byte(body[i]);
        frame_bytes += HEADER_BYTES + nsend;
        frames_sent++;
    endtask

    // line noise with random '>' bytes, which can form a full sync; last byte never '>' so no partial sync is left
    task automatic send_noise();
        int n;
        logic [7:0] b;
        n = $urandom_range(1, 6);
        repeat (n) begin
            b = ($urandom_range(0, 2) == 0) ? SYNC_BYTE : 8'($urandom);
            send_byte(b);
        end
        b = 8'($urandom);
        if (b == SYNC_BYTE)
            b = 8'h00;
        send_byte(b);
    endtask

    // mostly well-formed frames with random content, biased to short payloads
    task automatic send_random_frame();
        logic [7:0]  sender;
        logic [15:0] len;
        int          room;
        int          pick;
        bit          ok;
        int          cut;
        sender = ($urandom_range(0, 7) == 0) ? cur_own : 8'($urandom);
        len    = 16'($urandom);
        room   = cur_max - HEADER_BYTES;
        // frames that get through carry short payloads; full-range lengths
        // only show up on frames that get rejected
        if (sender != cur_own && int'(len) <= room) begin
            pick = $urandom_range(0, 19);
            if (pick < 3)
                len = 16'd0;
            else if (pick == 3 && room <= 200)
                len = 16'(room);            // exactly at the size limit
            else if (pick == 4)
                len = 16'($urandom_range(0, (room < 200) ? room : 200));
            else
                len = 16'($urandom_range(0, (room < 24) ? room : 24));
        end
        ok  = ($urandom_range(0, 5) != 0);
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 3) : 0;
        send_frame(8'($urandom), sender, len, ok, cut);
    endtask

    task automatic run_random_phase();
        int start;
        start = frame_bytes;
        while (frame_bytes - start < PHASE_BYTES) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_random_frame();
        end
    endtask

    // stop sending and let every owed word drain, plus pipeline slack
    task automatic wait_drained(input int slack);
        @(negedge aclk);
        s_valid = 1'b0;
        while (tracker.due_words.size() != 0) @(posedge aclk);
        repeat (slack) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        if (idx == REG_OWN_ID)
            cur_own = value[7:0];
        else
            cur_max = int'(value);
    endtask

    task automatic set_regs(input logic [7:0] own, input logic [16:0] max_b);
        wait_drained(DRAIN_CYCLES);
        write_reg(REG_OWN_ID, {9'd0, own});
        write_reg(REG_MAX_BYTES, max_b);
    endtask

    initial begin
        // reset: held low from time zero, then released at a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed, reset settings (own id 0, max 65545)
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(SYNC_BYTE, 8'h11, 16'd2, 1'b1, 0);     // four '>' : topic is '>'
        send_frame(8'hFF, 8'hFF, 16'd0, 1'b1, 0);         // empty, crc good
        send_frame(8'h00, 8'h80, 16'd0, 1'b0, 0);         // empty, crc bad
        send_frame(8'h42, 8'h00, 16'hFFFF, 1'b1, 0);      // own sender; 0xFFFF length still fits the limit
        send_frame(8'h5A, 8'h01, 16'd1, 1'b0, 0);         // one byte, crc bad
        run_random_phase();

        // widest size limit, own id at top
        set_regs(8'hFF, 17'h1FFFF);
        run_random_phase();

        // smallest legal limit: only empty frames fit
        set_regs(8'h00, 17'd10);
        send_frame(8'h01, 8'h02, 16'd0, 1'b1, 0);
        send_frame(8'h01, 8'h02, 16'd1, 1'b1, 0);         // one over -> too large
        run_random_phase();

        // limit below the header size rejects everything not already own
        set_regs(8'($urandom), 17'd0);
        run_random_phase();

        // one under the largest frame: full-length header is too large
        set_regs(8'h5A, 17'd65544);
        send_frame(8'h77, 8'h00, 16'hFFFF, 1'b1, 0);
        run_random_phase();

        // random settings, tight limit; no idling from here on
        set_regs(8'($urandom), 17'($urandom_range(10, 200)));
        quiet = 1'b1;
        run_random_phase();

        wait_drained(20);
        $display("sent %0d frames (%0d frame bytes), checked %0d result words",
                 frames_sent, frame_bytes, tracker.words_checked);
        $display("frame endings: good %0d, bad %0d, own sender %0d, too large %0d",
                 tracker.verdicts[ST_GOOD], tracker.verdicts[ST_BAD],
                 tracker.verdicts[ST_OWN], tracker.verdicts[ST_LARGE]);
        if (tracker.errors == 0) begin
            $display("sync_frame_receiver_crc16 test passed");
        end else begin
            $display("sync_frame_receiver_crc16 test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/sfr_pkg.sv
hdl/sfr_parse.sv
hdl/sync_frame_receiver_crc16.sv
dv/testbench.sv
